### rtl/ciq_pkg.sv
package ciq_pkg;

   // Ring size and derived widths
   localparam int DEPTH = 64;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CAP_W = 7;
   localparam int WORD_W = 32;

   // Command codes
   localparam logic [2:0] CMD_ENQ    = 3'd0;
   localparam logic [2:0] CMD_DEQ    = 3'd1;
   localparam logic [2:0] CMD_PEEK   = 3'd2;
   localparam logic [2:0] CMD_SEARCH = 3'd3;
   localparam logic [2:0] CMD_CLR    = 3'd4;

   // Status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   // Register map
   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic [2:0]               command;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] data;
      logic [PTR_W-1:0]         slot_index;
      logic [CNT_W-1:0]         occupancy;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   // Capacity clamped to 1..DEPTH
   function automatic logic [CNT_W-1:0] cap_in_use(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] c;
      if (cap == '0) begin
         c = CNT_W'(1);
      end else if (32'(cap) > DEPTH) begin
         c = CNT_W'(DEPTH);
      end else begin
         c = CNT_W'(cap);
      end
      return c;
   endfunction

   // Pointer step with wrap at the capacity in use
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] n;
      n = (CNT_W+1)'(p) + (CNT_W+1)'(1);
      if (n >= (CNT_W+1)'(cap)) begin
         return '0;
      end
      return n[PTR_W-1:0];
   endfunction

endpackage

### rtl/ciq_ram.sv
module ciq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/circular_int_queue_top.sv
// Ring-buffer queue of signed 32-bit words held in a single-port-write,
// registered-read RAM of 64 slots, of which the first "capacity" (register 0,
// 1..64, reset 64; issue a clear after changing it) are used. Each request
// carries a command (enqueue, dequeue, peek, search, clear) and yields exactly
// one response with status, data, slot index, occupancy and empty/full flags.
// Enqueue, clear, refused operations and unused codes are answered in the
// cycle after acceptance, so they can be issued every cycle while responses
// are taken. Dequeue and peek read the head slot via the registered RAM read
// port and answer from the read state. Search examines up to the occupancy
// slots, stepping through the RAM read port one slot per cycle from the oldest
// entry. Slot contents come up undefined after reset and need no clearing pass.
module circular_int_queue_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ciq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ciq_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import ciq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]  scan_left_ff, scan_left_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic [CAP_W-1:0]  capacity_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]  cap;
   logic              accept;
   logic              out_free;
   logic              cfg_write;
   logic              wr_en;
   logic [PTR_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              res_done;
   logic [1:0]        res_status;
   logic [WORD_W-1:0] res_data;
   logic [PTR_W-1:0]  res_slot;

   // Configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? 32'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(DEPTH);
      end else if (cfg_write && csr_paddr[2] == REG_CAPACITY) begin
         capacity_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   // Handshake
   assign cap       = cap_in_use(capacity_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Slot memory
   ciq_ram #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(req_data.value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Command sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      key_in       = key_ff;
      wr_en        = 1'b0;
      rd_addr      = head_ff;
      res_done     = 1'b0;
      res_status   = STAT_OK;
      res_data     = '0;
      res_slot     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.command) inside
                  CMD_ENQ: begin
                     res_done = 1'b1;
                     if (count_ff >= cap) begin
                        res_status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = advance(tail_ff, cap);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DEQ, CMD_PEEK: begin
                     if (count_ff == '0) begin
                        res_done   = 1'b1;
                        res_status = STAT_EMPTY;
                     end else begin
                        state_in = S_READ;
                        if (req_data.command == CMD_DEQ) begin
                           head_in  = advance(head_ff, cap);
                           count_in = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        res_done   = 1'b1;
                        res_status = STAT_NOTFOUND;
                     end else begin
                        state_in     = S_SCAN;
                        scan_ptr_in  = head_ff;
                        scan_left_in = count_ff;
                        key_in       = req_data.value;
                     end
                  end
                  CMD_CLR: begin
                     res_done = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                     res_done = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            res_done = 1'b1;
            res_data = rd_data;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // rd_data holds the slot at scan_ptr_ff; fetch the next one meanwhile
            rd_addr = advance(scan_ptr_ff, cap);
            if (rd_data == key_ff) begin
               res_done = 1'b1;
               res_slot = scan_ptr_ff;
               state_in = S_IDLE;
            end else if (scan_left_ff == CNT_W'(1)) begin
               res_done   = 1'b1;
               res_status = STAT_NOTFOUND;
               state_in   = S_IDLE;
            end else begin
               scan_ptr_in  = rd_addr;
               scan_left_in = scan_left_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Output register
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (res_done) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = res_status;
         rsp_in.data       = res_data;
         rsp_in.slot_index = res_slot;
         rsp_in.occupancy  = count_in;
         rsp_in.is_empty   = (count_in == '0);
         rsp_in.is_full    = (count_in >= cap);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ptr_ff  <= scan_ptr_in;
      scan_left_ff <= scan_left_in;
      key_ff       <= key_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTH
   // Occupancy never exceeds the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("occupancy above ring size");

   // Output register is empty whenever a read or scan is in flight
   a_busy_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_SCAN) |-> !rsp_valid_ff)
      else $error("response pending during multi-cycle command");

   // A dequeue or peek read always produces a response next cycle
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("read did not complete");

   // An enqueue that is not refused grows the occupancy by one
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.command == CMD_ENQ && count_ff < cap)
         |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("enqueue did not advance occupancy");
`endif

endmodule

### dv/circular_int_queue_top_tb.sv
module circular_int_queue_top_tb;
   import ciq_pkg::*;

   // Spare command codes: the block treats them as no-ops
   localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
   localparam logic [2:0] CMD_SPARE_MID = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

   // Capacity register byte address
   localparam logic [2:0] CAP_ADDR = 3'(REG_CAPACITY) << 2;

   localparam int PHASES     = 12;
   localparam int PHASE_ITEMS = 150;
   localparam int POOL_SIZE  = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   circular_int_queue_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Queue shadow state
   logic signed [WORD_W-1:0] ring_mem [DEPTH] = '{default: '0};
   logic [PTR_W-1:0]         rd_ptr = '0;
   logic [PTR_W-1:0]         wr_ptr = '0;
   logic [CNT_W-1:0]         fill_level = '0;
   logic [CAP_W-1:0]         capacity_setting = CAP_W'(DEPTH);

   req_type cmd_backlog [$];
   rsp_type replies_due [$];
   int      issued_total = 0;
   int      answered_total = 0;
   int      fault_count = 0;
   bit      gaps_on = 1'b1;
   int      gap_left = 0;
   int      stall_left = 0;

   // Capacity clamped into 1..DEPTH
   function automatic logic [CNT_W-1:0] usable_slots(input logic [CAP_W-1:0] c);
      if (c == '0) begin
         return CNT_W'(1);
      end
      if (int'(c) > DEPTH) begin
         return CNT_W'(DEPTH);
      end
      return CNT_W'(c);
   endfunction

   // Pointer step, wrapping to slot 0 at the usable size
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] lim);
      int n;
      n = int'(p) + 1;
      return (n >= int'(lim)) ? '0 : PTR_W'(n);
   endfunction

   // Apply one queue command to the shadow state and return the reply it yields
   function automatic rsp_type apply_queue_cmd(input req_type item);
      rsp_type          r;
      logic [CNT_W-1:0] lim;
      logic [PTR_W-1:0] p;
      bit               hit;
      r = '0;
      r.status = STAT_OK;
      lim = usable_slots(capacity_setting);
      case (item.command)
         CMD_ENQ: begin
            if (fill_level >= lim) begin
               r.status = STAT_FULL;
            end else begin
               ring_mem[wr_ptr] = item.value;
               wr_ptr = next_ptr(wr_ptr, lim);
               fill_level = fill_level + CNT_W'(1);
            end
         end
         CMD_DEQ: begin
            if (fill_level == '0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.data = ring_mem[rd_ptr];
               rd_ptr = next_ptr(rd_ptr, lim);
               fill_level = fill_level - CNT_W'(1);
            end
         end
         CMD_PEEK: begin
            if (fill_level == '0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.data = ring_mem[rd_ptr];
            end
         end
         CMD_SEARCH: begin
            // scan oldest to newest, first match wins
            p = rd_ptr;
            hit = 1'b0;
            for (int i = 0; i < int'(fill_level) && !hit; i++) begin
               if (ring_mem[p] == item.value) begin
                  r.slot_index = p;
                  hit = 1'b1;
               end else begin
                  p = next_ptr(p, lim);
               end
            end
            if (!hit) begin
               r.status = STAT_NOTFOUND;
            end
         end
         CMD_CLR: begin
            rd_ptr = '0;
            wr_ptr = '0;
            fill_level = '0;
         end
         default: ;
      endcase
      r.occupancy = fill_level;
      r.is_empty  = (fill_level == '0);
      r.is_full   = (fill_level >= lim);
      return r;
   endfunction

   function automatic string show_reply(input rsp_type r);
      return $sformatf("status=%0d data=%0d slot=%0d occ=%0d empty=%0b full=%0b",
                       r.status, r.data, r.slot_index, r.occupancy, r.is_empty, r.is_full);
   endfunction

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // Mostly short gaps, a few long ones
   function automatic int pick_gap_len();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Driver: present backlog items, hold while stalled
   always @(posedge clock) begin : item_driver
      logic next_valid;
      if (!reset) begin
         next_valid = req_valid && req_stall;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_backlog.size() > 0) begin
               req_data <= cmd_backlog.pop_front();
               next_valid = 1'b1;
               gap_left = (gaps_on && $urandom_range(0, 1) == 1) ? pick_gap_len() : 0;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: predict on accepted items, check accepted replies, random stalls
   always @(posedge clock) begin : reply_monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            replies_due.push_back(apply_queue_cmd(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               log_fault($sformatf("unexpected reply: %s", show_reply(rsp_data)));
            end else begin
               want = replies_due.pop_front();
               answered_total++;
               if (rsp_data.status !== want.status || rsp_data.data !== want.data ||
                   rsp_data.slot_index !== want.slot_index ||
                   rsp_data.occupancy !== want.occupancy ||
                   rsp_data.is_empty !== want.is_empty || rsp_data.is_full !== want.is_full)
               begin
                  log_fault($sformatf("reply mismatch: expected %s, got %s",
                                      show_reply(want), show_reply(rsp_data)));
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (gaps_on && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap_len();
            end
         end
      end
   end

   task automatic queue_cmd(input logic [2:0] c, input logic [WORD_W-1:0] v);
      req_type it;
      it.command = c;
      it.value = v;
      cmd_backlog.push_back(it);
      issued_total++;
   endtask

   task automatic wait_idle();
      while (answered_total != issued_total) begin
         @(posedge clock);
      end
   endtask

   // Optional capacity write, then read back and compare
   task automatic csr_capacity(input bit do_write, input logic [CAP_W-1:0] v);
      logic [31:0] got;
      if (do_write) begin
         @(posedge clock);
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= CAP_ADDR;
         csr_pwdata <= {25'($urandom), v};
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         capacity_setting = v;
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
      end
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CAP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== 32'(capacity_setting)) begin
         log_fault($sformatf("capacity readback: expected %0d, got %0d",
                             capacity_setting, got));
      end
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0]  cap_plan [PHASES];
      logic [WORD_W-1:0] pool [POOL_SIZE];
      logic [CNT_W-1:0]  lim;
      logic [2:0]        op;
      logic [WORD_W-1:0] key;
      int                made;
      int                run;
      int                roll;
      bit                adding;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      csr_capacity(1'b0, '0);

      // Directed: empty refusals, spare codes, extreme words, hits and misses
      queue_cmd(CMD_PEEK, $urandom);
      queue_cmd(CMD_DEQ, $urandom);
      queue_cmd(CMD_SEARCH, '0);
      queue_cmd(CMD_SPARE_LO, $urandom);
      queue_cmd(CMD_SPARE_MID, $urandom);
      queue_cmd(CMD_SPARE_HI, $urandom);
      queue_cmd(CMD_ENQ, 32'h8000_0000);
      queue_cmd(CMD_ENQ, 32'h7FFF_FFFF);
      queue_cmd(CMD_ENQ, 32'hFFFF_FFFF);
      queue_cmd(CMD_ENQ, 32'h0000_0000);
      queue_cmd(CMD_SEARCH, 32'h7FFF_FFFF);
      queue_cmd(CMD_SEARCH, 32'hFFFF_FFFF);
      queue_cmd(CMD_SEARCH, 32'h0000_3039);
      queue_cmd(CMD_PEEK, $urandom);
      queue_cmd(CMD_DEQ, $urandom);
      queue_cmd(CMD_SEARCH, 32'h8000_0000);
      queue_cmd(CMD_SPARE_LO, $urandom);
      queue_cmd(CMD_CLR, $urandom);
      queue_cmd(CMD_PEEK, $urandom);
      queue_cmd(CMD_ENQ, 32'h5555_5555);
      queue_cmd(CMD_ENQ, 32'hAAAA_AAAA);
      queue_cmd(CMD_DEQ, $urandom);
      queue_cmd(CMD_DEQ, $urandom);
      queue_cmd(CMD_DEQ, $urandom);
      wait_idle();

      // Fill every slot to full, overflow once, then drain past empty
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool[i] = $urandom;
      end
      for (int i = 0; i <= DEPTH; i++) begin
         queue_cmd(CMD_ENQ, ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] :
                            32'($urandom));
      end
      for (int i = 0; i < 4; i++) begin
         queue_cmd(CMD_SEARCH, pool[$urandom_range(0, 7)]);
      end
      queue_cmd(CMD_PEEK, $urandom);
      for (int i = 0; i <= DEPTH; i++) begin
         queue_cmd(CMD_DEQ, $urandom);
      end

      cap_plan = '{7'd1, 7'd2, 7'd0, 7'd127, 7'd65, 7'd3, 7'd64, 7'd17,
                   7'd9, 7'd5, 7'd40, 7'd64};
      cap_plan[8] = CAP_W'($urandom_range(4, 63));
      cap_plan[10] = CAP_W'($urandom_range(4, 63));

      // Random phases: bursts of adds and removes over a small word pool
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         gaps_on = (ph % 3 != 1);
         csr_capacity(1'b1, cap_plan[ph]);
         // some phases keep the old pointers across the capacity change
         if (ph % 4 != 2) begin
            queue_cmd(CMD_CLR, $urandom);
         end
         lim = usable_slots(cap_plan[ph]);
         pool[0] = 32'h8000_0000;
         pool[1] = 32'h7FFF_FFFF;
         pool[2] = '0;
         pool[3] = '1;
         for (int i = 4; i < POOL_SIZE; i++) begin
            pool[i] = $urandom;
         end
         made = 0;
         while (made < PHASE_ITEMS) begin
            adding = 1'($urandom_range(0, 1));
            run = $urandom_range(1, int'(lim) + 3);
            for (int k = 0; k < run && made < PHASE_ITEMS; k++) begin
               roll = $urandom_range(0, 99);
               if (adding) begin
                  op = (roll < 80) ? CMD_ENQ : (roll < 88) ? CMD_SEARCH :
                       (roll < 93) ? CMD_PEEK : (roll < 96) ? CMD_DEQ :
                       (roll < 98) ? CMD_CLR :
                       3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
               end else begin
                  op = (roll < 55) ? CMD_DEQ : (roll < 75) ? CMD_PEEK :
                       (roll < 94) ? CMD_SEARCH : (roll < 97) ? CMD_ENQ :
                       (roll < 99) ? CMD_CLR :
                       3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
               end
               key = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] :
                     32'($urandom);
               queue_cmd(op, key);
               made++;
            end
         end
      end

      // Drain, then leave room for any stray reply
      wait_idle();
      repeat (80) @(posedge clock);
      if (fault_count == 0) begin
         $display("circular_int_queue_top regression: pass");
      end else begin
         $display("circular_int_queue_top regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #50_000_000;
      $display("circular_int_queue_top regression: fail");
      $finish;
   end

endmodule
